/* sv/rwr_pkg.sv */
// ----------------------------------------------------------------------------
// rwr_pkg: shared types and constants of the radial warp remap block
// Holds the request and result structures, register and curve codes, and the
// quarter-wave sine table used by the curve stage.
// ----------------------------------------------------------------------------
package rwr_pkg;

	localparam int unsigned MAX_WIDTH   = 256;
	localparam int unsigned MAX_HEIGHT  = 256;
	localparam int unsigned SINE_DEPTH  = 1024;
	localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
	localparam int unsigned SIN_AW      = $clog2(SINE_DEPTH);
	localparam int unsigned PIX_W       = 32;
	localparam int unsigned DIM_W       = 9;
	localparam int unsigned CFG_DW      = 12;
	localparam int unsigned CFG_IW      = 3;

	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		CURVE_COS   = 2'd0,
		CURVE_SIN   = 2'd1,
		CURVE_SQ    = 2'd2,
		CURVE_INVSQ = 2'd3
	} curve_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_FRAME_WIDTH  = 3'd0,
		CFG_FRAME_HEIGHT = 3'd1,
		CFG_CENTRE_X     = 3'd2,
		CFG_CENTRE_Y     = 3'd3,
		CFG_RADIUS       = 3'd4,
		CFG_CURVE_MODE   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		action_t           action;
		logic [7:0]        col;
		logic [7:0]        row;
		logic [PIX_W-1:0]  pixel_in;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel_out;
		logic              remapped;
	} res_t;

	typedef logic [16:0] sine_tab_t [SINE_DEPTH];

	// One table entry: odd Taylor series up to x^9 in Q2.30, rounded to Q.16.
	function automatic logic [16:0] sine_entry(int unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		x  = (longint'(i) * HALF_PI_Q30) / SINE_DEPTH;
		x2 = (x * x) >> 30;
		t  = x;
		s  = x;
		t  = ((t * x2) >> 30) / 6;
		s  = s - t;
		t  = ((t * x2) >> 30) / 20;
		s  = s + t;
		t  = ((t * x2) >> 30) / 42;
		s  = s - t;
		t  = ((t * x2) >> 30) / 72;
		s  = s + t;
		s  = (s + 8192) >> 14;
		if (s > 64'd65536) begin
			s = 64'd65536;
		end
		return s[16:0];
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		for (int unsigned i = 0; i < SINE_DEPTH; i++) begin
			tab[i] = sine_entry(i);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* sv/rwr_ram.sv */
// ----------------------------------------------------------------------------
// rwr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds while the
// read enable is low.
// ----------------------------------------------------------------------------
module rwr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  logic [WIDTH-1:0]          wr_data,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [WIDTH-1:0]          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* sv/radial_warp_remap.sv */
// ----------------------------------------------------------------------------
// radial_warp_remap: frame store with a radial lens-distortion lookup
// Loads write pixels into a frame store; queries return the pixel at the
// radially remapped source position, or their own, via a 20-stage pipeline.
// ----------------------------------------------------------------------------
// Usage
// The request channel (pix_valid, pix_stall, pix_req) carries loads and
// queries in one stream. A load writes pix_req.pixel_in at (col, row) and
// returns nothing; a query returns one result on the result channel
// (res_valid, res_stall, res). Results leave in request order.
// Throughput is one request per clock while the receiver does not stall.
// The depth comes from the square root (four stages), the two radius
// divisions (three and two stages per lane), the frame store's registered
// read and the remaining datapath registers.
// Loads write the store late in the pipe, at the same stage where queries
// read it, so every query sees exactly the loads that came before it.
// When the receiver stalls a waiting result, the whole pipe freezes and
// pix_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and restores the register defaults. The frame
// store is not cleared: a query of a never-written pixel returns junk.
// Registers are written through cfg_valid/cfg_ready (always ready) and must
// be written only while the pipe is empty.
// ----------------------------------------------------------------------------
module radial_warp_remap (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  rwr_pkg::req_t                  pix_req,
	output logic                           res_valid,
	input  logic                           res_stall,
	output rwr_pkg::res_t                  res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rwr_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [rwr_pkg::CFG_DW-1:0]     cfg_data
);

	import rwr_pkg::*;

	localparam int unsigned LAST   = 20;
	localparam int unsigned SQ_N   = 4;
	localparam int unsigned DA_N   = 6;
	localparam int unsigned DO_N   = 7;
	localparam int unsigned IDX_W  = 17 + SIN_AW + 1;

	// Sideband that travels with every request down the pipe.
	typedef struct packed {
		logic              vld;
		action_t           act;
		logic [7:0]        col;
		logic [7:0]        row;
		logic [PIX_W-1:0]  pix;
		logic              st;
		logic              ok;
		logic              neg_x;
		logic              neg_y;
		logic [11:0]       mag_x;
		logic [11:0]       mag_y;
	} side_t;

	typedef struct packed {
		logic [17:0] rem;
		logic [15:0] root;
		logic [31:0] v;
	} sq_t;

	typedef struct packed {
		logic [11:0] rem;
		logic [17:0] q;
		logic [17:0] lo;
	} dva_t;

	typedef struct packed {
		logic [16:0] rem;
		logic [13:0] q;
		logic [13:0] lo;
	} dvo_t;

	// Digit-by-digit square root, two bits of the radicand per step.
	function automatic sq_t sqrt_steps(sq_t x);
		sq_t         y;
		logic [19:0] r;
		logic [17:0] t;
		y = x;
		for (int i = 0; i < SQ_N; i++) begin
			r = {y.rem, y.v[31:30]};
			t = {y.root, 2'b01};
			if (r >= 20'(t)) begin
				y.rem  = 18'(r - 20'(t));
				y.root = {y.root[14:0], 1'b1};
			end else begin
				y.rem  = r[17:0];
				y.root = {y.root[14:0], 1'b0};
			end
			y.v = {y.v[29:0], 2'b00};
		end
		return y;
	endfunction

	// Restoring division of the scaled distance by the radius.
	function automatic dva_t div_a_steps(dva_t x, logic [11:0] den);
		dva_t        y;
		logic [12:0] t;
		y = x;
		for (int i = 0; i < DA_N; i++) begin
			t    = {y.rem, y.lo[17]};
			y.lo = {y.lo[16:0], 1'b0};
			if (t >= {1'b0, den}) begin
				y.rem = 12'(t - {1'b0, den});
				y.q   = {y.q[16:0], 1'b1};
			end else begin
				y.rem = t[11:0];
				y.q   = {y.q[16:0], 1'b0};
			end
		end
		return y;
	endfunction

	// Restoring division of the scaled offset by a.
	function automatic dvo_t div_o_steps(dvo_t x, logic [16:0] den);
		dvo_t        y;
		logic [17:0] t;
		y = x;
		for (int i = 0; i < DO_N; i++) begin
			t    = {y.rem, y.lo[13]};
			y.lo = {y.lo[12:0], 1'b0};
			if (t >= {1'b0, den}) begin
				y.rem = 17'(t - {1'b0, den});
				y.q   = {y.q[12:0], 1'b1};
			end else begin
				y.rem = t[16:0];
				y.q   = {y.q[12:0], 1'b0};
			end
		end
		return y;
	endfunction

	// Configuration registers.
	logic [8:0]   fw_q;
	logic [8:0]   fh_q;
	logic [11:0]  cx_q;
	logic [11:0]  cy_q;
	logic [11:0]  rad_q;
	curve_t       mode_q;
	logic [23:0]  rsq_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	// Pipeline.
	logic         adv;
	side_t        sd_s [1:LAST];
	side_t        sd_nx [2:LAST];
	logic [24:0]  d2_s3;
	logic [31:0]  v_s4;
	sq_t          sq_s [5:8];
	dva_t         dv_s [9:11];
	logic [16:0]  a_s12, a_s13, a_s14, a_s15, a_s16, a_s17;
	logic [SIN_AW-1:0] sidx_s12;
	logic         sbig_s12;
	logic [16:0]  sqop_s12;
	logic [16:0]  sin_s13;
	logic [33:0]  sqp_s13;
	logic [16:0]  a2_s14;
	logic [28:0]  px_s15, py_s15;
	logic [29:0]  nx_s16, ny_s16;
	logic         satx_s16, saty_s16, satx_s17, saty_s17, satx_s18, saty_s18;
	dvo_t         ox_s [17:18];
	dvo_t         oy_s [17:18];
	logic [STORE_AW-1:0] src_addr_s19;

	// Combinational stage values.
	logic [12:0]  dx, dy;
	logic         in_frame;
	logic         in_circle;
	logic [17:0]  a_q18;
	logic [16:0]  a_c, b_c, arg_c;
	logic [IDX_W-1:0] idx_full;
	logic [16:0]  sq_rnd;
	logic [16:0]  a2_c;
	logic [13:0]  offx, offy;
	logic [16:0]  posx, posy;
	logic         srcx_ok, srcy_ok;
	logic [STORE_AW-1:0] own_addr;
	logic [STORE_AW-1:0] src_addr_c;
	logic [PIX_W-1:0]    own_rd;
	logic [PIX_W-1:0]    src_rd;
	logic         wr_en;
	logic         res_valid_q;
	res_t         res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= 9'd256;
			fh_q   <= 9'd256;
			cx_q   <= 12'd2048;
			cy_q   <= 12'd2048;
			rad_q  <= 12'd2048;
			mode_q <= CURVE_COS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:  fw_q   <= cfg_data[8:0];
				CFG_FRAME_HEIGHT: fh_q   <= cfg_data[8:0];
				CFG_CENTRE_X:     cx_q   <= cfg_data[11:0];
				CFG_CENTRE_Y:     cy_q   <= cfg_data[11:0];
				CFG_RADIUS:       rad_q  <= cfg_data[11:0];
				CFG_CURVE_MODE:   mode_q <= curve_t'(cfg_data[1:0]);
				default: begin
				end
			endcase
		end
	end

	// The squared radius is registered from the radius register, well before a
	// request can reach the inside test.
	always_ff @(posedge clk) begin
		rsq_q <= 24'(rad_q) * 24'(rad_q);
	end

	assign w_eff = (fw_q > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : fw_q;
	assign h_eff = (fh_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_q;

	// The whole pipe moves unless a finished result is held by the receiver.
	assign adv       = !res_valid_q || !res_stall;
	assign pix_stall = !adv;

	always_comb begin
		// Offsets from the centre in Q.4, kept as sign and magnitude.
		dx = {1'b0, sd_s[1].col, 4'b0000} - {1'b0, cx_q};
		dy = {1'b0, sd_s[1].row, 4'b0000} - {1'b0, cy_q};
		in_frame = ({1'b0, sd_s[1].col} < w_eff) && ({1'b0, sd_s[1].row} < h_eff);

		// Inside test is exact; the centre itself is excluded.
		in_circle = (d2_s3 != 25'd0) && ({1'b0, rsq_q} >= d2_s3);

		// a saturates at one in Q1.16.
		a_q18 = dv_s[11].q;
		a_c   = (a_q18 > 18'(ONE_Q16)) ? ONE_Q16 : a_q18[16:0];
		b_c   = 17'(ONE_Q16 - a_c);
		arg_c = (mode_q == CURVE_COS) ? b_c : a_c;
		idx_full = (IDX_W'(arg_c) * IDX_W'(SINE_DEPTH) + IDX_W'(32768)) >> 16;

		sq_rnd = 17'((sqp_s13 + 34'd32768) >> 16);
		case (mode_q)
			CURVE_COS:   a2_c = 17'(ONE_Q16 - sin_s13);
			CURVE_SIN:   a2_c = sin_s13;
			CURVE_SQ:    a2_c = sq_rnd;
			default:     a2_c = 17'(ONE_Q16 - sq_rnd);
		endcase

		// An offset too large for any frame saturates and lands outside.
		offx = satx_s18 ? 14'h3FFF : ox_s[18].q;
		offy = saty_s18 ? 14'h3FFF : oy_s[18].q;
		posx = sd_s[18].neg_x ? (17'(cx_q) + 17'd8 - 17'(offx))
		                      : (17'(cx_q) + 17'd8 + 17'(offx));
		posy = sd_s[18].neg_y ? (17'(cy_q) + 17'd8 - 17'(offy))
		                      : (17'(cy_q) + 17'd8 + 17'(offy));
		srcx_ok = !posx[16] && (posx[15:4] < 12'(w_eff));
		srcy_ok = !posy[16] && (posy[15:4] < 12'(h_eff));
		src_addr_c = STORE_AW'(STORE_AW'(posy[15:4]) * STORE_AW'(MAX_WIDTH)
		                       + STORE_AW'(posx[15:4]));

		own_addr = STORE_AW'(STORE_AW'(sd_s[19].row) * STORE_AW'(MAX_WIDTH)
		                     + STORE_AW'(sd_s[19].col));
		wr_en = adv && sd_s[19].vld && (sd_s[19].act == ACT_LOAD) && sd_s[19].st;
	end

	// Next sideband of each stage: a copy of the stage before, plus the
	// offsets' sign and magnitude and the remap-deciding checks.
	always_comb begin
		for (int i = 2; i <= LAST; i++) begin
			sd_nx[i] = sd_s[i-1];
		end
		sd_nx[2].ok    = (sd_s[1].act == ACT_QUERY) && sd_s[1].st && in_frame;
		sd_nx[2].neg_x = dx[12];
		sd_nx[2].neg_y = dy[12];
		sd_nx[2].mag_x = dx[12] ? 12'(-dx) : dx[11:0];
		sd_nx[2].mag_y = dy[12] ? 12'(-dy) : dy[11:0];
		sd_nx[4].ok    = sd_s[3].ok && in_circle;
		sd_nx[12].ok   = sd_s[11].ok && (a_c != 17'd0);
		sd_nx[19].ok   = sd_s[18].ok && srcx_ok && srcy_ok;
	end

	// Sideband and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) begin
				sd_s[i].vld <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (adv) begin
			sd_s[1].vld   <= pix_valid;
			sd_s[1].act   <= pix_req.action;
			sd_s[1].col   <= pix_req.col;
			sd_s[1].row   <= pix_req.row;
			sd_s[1].pix   <= pix_req.pixel_in;
			sd_s[1].st    <= (32'(pix_req.col) < MAX_WIDTH) && (32'(pix_req.row) < MAX_HEIGHT);
			sd_s[1].ok    <= 1'b0;
			sd_s[1].neg_x <= 1'b0;
			sd_s[1].neg_y <= 1'b0;
			sd_s[1].mag_x <= 12'd0;
			sd_s[1].mag_y <= 12'd0;
			for (int i = 2; i <= LAST; i++) begin
				sd_s[i] <= sd_nx[i];
			end
			res_valid_q   <= sd_s[LAST].vld && (sd_s[LAST].act == ACT_QUERY);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s3 <= 25'(sd_s[2].mag_x) * 25'(sd_s[2].mag_x)
			       + 25'(sd_s[2].mag_y) * 25'(sd_s[2].mag_y);
			v_s4  <= {d2_s3[23:0], 8'h00};

			sq_s[5] <= sqrt_steps('{rem: 18'd0, root: 16'd0, v: v_s4});
			for (int k = 6; k <= 8; k++) begin
				sq_s[k] <= sqrt_steps(sq_s[k-1]);
			end

			dv_s[9] <= div_a_steps('{rem: 12'(sq_s[8].root >> 6), q: 18'd0,
			                         lo: {sq_s[8].root[5:0], 12'h000}}, rad_q);
			for (int k = 10; k <= 11; k++) begin
				dv_s[k] <= div_a_steps(dv_s[k-1], rad_q);
			end

			a_s12    <= a_c;
			sidx_s12 <= idx_full[SIN_AW-1:0];
			sbig_s12 <= idx_full >= IDX_W'(SINE_DEPTH);
			sqop_s12 <= (mode_q == CURVE_SQ) ? a_c : b_c;

			a_s13   <= a_s12;
			sin_s13 <= sbig_s12 ? ONE_Q16 : SINE_TAB[sidx_s12];
			sqp_s13 <= 34'(sqop_s12) * 34'(sqop_s12);

			a_s14  <= a_s13;
			a2_s14 <= a2_c;

			a_s15  <= a_s14;
			px_s15 <= 29'(sd_s[14].mag_x) * 29'(a2_s14);
			py_s15 <= 29'(sd_s[14].mag_y) * 29'(a2_s14);

			a_s16    <= a_s15;
			nx_s16   <= 30'(px_s15) + 30'(a_s15 >> 1);
			ny_s16   <= 30'(py_s15) + 30'(a_s15 >> 1);
			satx_s16 <= (31'(px_s15) + 31'(a_s15 >> 1)) >= {a_s15, 14'h0000};
			saty_s16 <= (31'(py_s15) + 31'(a_s15 >> 1)) >= {a_s15, 14'h0000};

			a_s17    <= a_s16;
			satx_s17 <= satx_s16;
			saty_s17 <= saty_s16;
			ox_s[17] <= div_o_steps('{rem: 17'(nx_s16 >> 14), q: 14'd0,
			                          lo: nx_s16[13:0]}, a_s16);
			oy_s[17] <= div_o_steps('{rem: 17'(ny_s16 >> 14), q: 14'd0,
			                          lo: ny_s16[13:0]}, a_s16);

			satx_s18 <= satx_s17;
			saty_s18 <= saty_s17;
			ox_s[18] <= div_o_steps(ox_s[17], a_s17);
			oy_s[18] <= div_o_steps(oy_s[17], a_s17);

			src_addr_s19 <= src_addr_c;

			res_q.pixel_out <= !sd_s[LAST].st ? '0 : (sd_s[LAST].ok ? src_rd : own_rd);
			res_q.remapped  <= sd_s[LAST].ok;
		end
	end

	// Two copies of the frame store: one for the source read, one for the
	// query's own pixel. Both take every load.
	rwr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_src_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (own_addr),
		.wr_data (sd_s[19].pix),
		.rd_en   (adv),
		.rd_addr (src_addr_s19),
		.rd_data (src_rd)
	);

	rwr_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_own_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (own_addr),
		.wr_data (sd_s[19].pix),
		.rd_en   (adv),
		.rd_addr (own_addr),
		.rd_data (own_rd)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* sv/rwr_chk.sv */
// ----------------------------------------------------------------------------
// rwr_chk: port-level checks of the radial warp remap block
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module rwr_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pix_valid,
	input  logic           pix_stall,
	input  logic           res_valid,
	input  logic           res_stall,
	input  rwr_pkg::res_t  res
);

	import rwr_pkg::*;

	// A held result stays put until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// The block only refuses requests when its own result is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("request stalled without a held result");

	// A held result always freezes the pipe behind it.
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |-> pix_stall)
		else $error("pipe kept moving behind a held result");

endmodule

bind radial_warp_remap rwr_chk u_rwr_chk (.*);

/* tb/radial_warp_remap_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_warp_remap_tb: self-checking bench for the radial warp remap block
// A short table of loads and queries is run first, then several register
// settings, each followed by random loads and queries. Every query result is
// matched to a literal or to a behavioral predictor with its own frame store.
// ----------------------------------------------------------------------------
module radial_warp_remap_tb;
	import rwr_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES   = 30;
	localparam int unsigned QUERIES_PER_SET = 25;
	localparam logic [CFG_IW-1:0] CFG_SPARE = CFG_IW'(CFG_CURVE_MODE) + 1'b1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                pix_valid = 1'b0;
	logic                pix_stall;
	req_t                pix_req = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	res_t                res;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [CFG_DW-1:0]   cfg_data = '0;

	// Shadow of the block: registers, frame store, and which entries hold data.
	logic [8:0]          fw_q, fh_q;
	logic [11:0]         cx_q, cy_q, rad_q;
	curve_t              curve_q;
	logic [31:0]         frame_shadow [STORE_DEPTH];
	bit                  pixel_loaded [STORE_DEPTH];
	logic [16:0]         quarter_sine [SINE_DEPTH];

	res_t                pending_pixels [$];
	int unsigned         error_count = 0;
	int unsigned         idle_cycles = 0;
	int unsigned         sent_count = 0;

	radial_warp_remap uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_req   (pix_req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Floor square root by bisection; the argument stays below 2**33 here.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		lo = 0;
		hi = 64'd1 << 17;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= v) lo = mid;
			else hi = mid - 1;
		end
		return lo;
	endfunction

	function automatic longint unsigned sine_of(longint unsigned a);
		longint unsigned idx;
		idx = (a * SINE_DEPTH + 32768) >> 16;
		return (idx >= SINE_DEPTH) ? 64'd65536 : longint'(quarter_sine[idx]);
	endfunction

	// Bends the normalized radius a (Q1.16) through the selected curve.
	function automatic longint unsigned bend_radius(longint unsigned a);
		longint unsigned b;
		b = 65536 - a;
		case (curve_q)
			CURVE_COS: return 65536 - sine_of(b);
			CURVE_SIN: return sine_of(a);
			CURVE_SQ:  return (a * a + 32768) >> 16;
			default:   return 65536 - ((b * b + 32768) >> 16);
		endcase
	endfunction

	// One axis of the source position in whole pixels, -1 when left of zero.
	function automatic longint source_axis(longint diff, longint centre,
			longint unsigned a2, longint unsigned a);
		longint unsigned mag;
		longint off;
		longint pos;
		mag = (diff < 0) ? -diff : diff;
		off = (mag * a2 + a / 2) / a;
		pos = centre + ((diff < 0) ? -off : off) + 8;
		return (pos < 0) ? -1 : pos / 16;
	endfunction

	// Store index that a query at (col, row) is remapped from, or -1 when the
	// query keeps its own pixel.
	function automatic int remap_source(logic [7:0] col, logic [7:0] row);
		longint w, h, dx, dy, sx, sy;
		longint unsigned d2, r, d, a, a2;
		w = (fw_q > MAX_WIDTH) ? MAX_WIDTH : fw_q;
		h = (fh_q > MAX_HEIGHT) ? MAX_HEIGHT : fh_q;
		if (col >= w || row >= h) return -1;
		dx = longint'(col) * 16 - longint'(cx_q);
		dy = longint'(row) * 16 - longint'(cy_q);
		d2 = dx * dx + dy * dy;
		r  = rad_q;
		if (d2 == 0 || r == 0 || d2 > r * r) return -1;
		d = floor_sqrt(d2 << 8);
		a = (d * 4096) / r;
		if (a > 65536) a = 65536;
		if (a == 0) return -1;
		a2 = bend_radius(a);
		sx = source_axis(dx, cx_q, a2, a);
		sy = source_axis(dy, cy_q, a2, a);
		if (sx < 0 || sy < 0 || sx >= w || sy >= h) return -1;
		return int'(sy * MAX_WIDTH + sx);
	endfunction

	function automatic res_t warped_pixel(logic [7:0] col, logic [7:0] row);
		int src;
		res_t r;
		src = remap_source(col, row);
		if (src < 0) begin
			r.pixel_out = frame_shadow[{row, col}];
			r.remapped  = 1'b0;
		end else begin
			r.pixel_out = frame_shadow[src];
			r.remapped  = 1'b1;
		end
		return r;
	endfunction

	// Offers one request and holds it until it is taken. A query's expected
	// result is either the literal given or the predicted one. After the
	// request the sender idles at random, except in a quiet stretch.
	task automatic send_request(req_t r, bit literal, res_t lit_res);
		pix_valid <= 1'b1;
		pix_req   <= r;
		do @(posedge clk); while (pix_stall);
		if (r.action == ACT_LOAD) begin
			frame_shadow[{r.row, r.col}] = r.pixel_in;
			pixel_loaded[{r.row, r.col}] = 1'b1;
		end else begin
			pending_pixels.push_back(literal ? lit_res : warped_pixel(r.col, r.row));
		end
		sent_count++;
		if (!(sent_count >= 300 && sent_count < 420) && $urandom_range(99) < 37) begin
			pix_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 37);
		end
	endtask

	task automatic send_load(logic [7:0] col, logic [7:0] row, logic [31:0] pix);
		req_t r;
		r.action   = ACT_LOAD;
		r.col      = col;
		r.row      = row;
		r.pixel_in = pix;
		send_request(r, 1'b0, '0);
	endtask

	// A query may only touch loaded pixels, so its own and its source pixel
	// are loaded first when they are still empty.
	task automatic send_query(logic [7:0] col, logic [7:0] row, bit literal,
			res_t lit_res);
		req_t r;
		int src;
		if (!pixel_loaded[{row, col}]) send_load(col, row, $urandom);
		src = remap_source(col, row);
		if (src >= 0 && !pixel_loaded[src])
			send_load(src[7:0], src[15:8], $urandom);
		r.action   = ACT_QUERY;
		r.col      = col;
		r.row      = row;
		r.pixel_in = $urandom;
		send_request(r, literal, lit_res);
	endtask

	// Register writes happen only with the pipe drained; loads leave nothing
	// to wait on, so the pipe depth is waited out as well. Each write drops
	// cfg_valid again before the shadow registers are updated.
	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_FRAME_WIDTH:  fw_q = val[8:0];
			CFG_FRAME_HEIGHT: fh_q = val[8:0];
			CFG_CENTRE_X:     cx_q = val;
			CFG_CENTRE_Y:     cy_q = val;
			CFG_RADIUS:       rad_q = val;
			CFG_CURVE_MODE:   curve_q = curve_t'(val[1:0]);
			default: ;
		endcase
	endtask

	task automatic drain_pipe();
		pix_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	typedef struct {
		action_t     act;
		logic [7:0]  col;
		logic [7:0]  row;
		logic [31:0] pix;
		bit          literal;
		res_t        want;
	} step_t;

	// Directed table under the reset settings: centre (128,128), radius 128.
	// Literal rows are the exact centre and pixels outside the circle.
	step_t directed [] = '{
		'{ACT_LOAD,  8'd128, 8'd128, 32'hDEADBEEF, 1'b0, '0},
		'{ACT_QUERY, 8'd128, 8'd128, 32'h0,        1'b1, '{32'hDEADBEEF, 1'b0}},
		'{ACT_LOAD,  8'd0,   8'd0,   32'h00000000, 1'b0, '0},
		'{ACT_QUERY, 8'd0,   8'd0,   32'hFFFFFFFF, 1'b1, '{32'h00000000, 1'b0}},
		'{ACT_LOAD,  8'd255, 8'd255, 32'hFFFFFFFF, 1'b0, '0},
		'{ACT_QUERY, 8'd255, 8'd255, 32'h0,        1'b1, '{32'hFFFFFFFF, 1'b0}},
		'{ACT_LOAD,  8'd0,   8'd0,   32'hA5A5A5A5, 1'b0, '0},
		'{ACT_QUERY, 8'd0,   8'd0,   32'h0,        1'b1, '{32'hA5A5A5A5, 1'b0}},
		'{ACT_LOAD,  8'd0,   8'd255, 32'h5A5A5A5A, 1'b0, '0},
		'{ACT_QUERY, 8'd0,   8'd255, 32'h0,        1'b1, '{32'h5A5A5A5A, 1'b0}},
		// The rest are checked against the predictor: the rim, the axes, two
		// neighbours of the centre and assorted points, one just outside the circle.
		'{ACT_QUERY, 8'd128, 8'd0,   32'h0, 1'b0, '0},
		'{ACT_QUERY, 8'd0,   8'd128, 32'h0, 1'b0, '0},
		'{ACT_QUERY, 8'd255, 8'd128, 32'h0, 1'b0, '0},
		'{ACT_QUERY, 8'd128, 8'd255, 32'h0, 1'b0, '0},
		'{ACT_QUERY, 8'd129, 8'd128, 32'h0, 1'b0, '0},
		'{ACT_QUERY, 8'd128, 8'd127, 32'h0, 1'b0, '0},
		'{ACT_QUERY, 8'd200, 8'd60,  32'h0, 1'b0, '0},
		'{ACT_QUERY, 8'd60,  8'd90,  32'h0, 1'b0, '0},
		'{ACT_QUERY, 8'd37,  8'd170, 32'h0, 1'b0, '0},
		'{ACT_QUERY, 8'd219, 8'd219, 32'h0, 1'b0, '0}
	};

	// Register sets: reset values, size above the store with the origin as centre
	// and the largest radius, a one-pixel frame centred on the far corner, zero
	// width and zero radius, and several ordinary frames under varied curves.
	typedef struct {
		logic [CFG_DW-1:0] fw, fh, cx, cy, rad;
		curve_t            crv;
	} reg_set_t;

	reg_set_t reg_sets [] = '{
		'{12'd256, 12'd256, 12'd2048, 12'd2048, 12'd2048, CURVE_COS},
		'{12'd511, 12'd300, 12'd0,    12'd0,    12'd4095, CURVE_SIN},
		'{12'd1,   12'd1,   12'd4095, 12'd4095, 12'd1,    CURVE_SQ},
		'{12'd64,  12'd40,  12'd512,  12'd320,  12'd300,  CURVE_INVSQ},
		'{12'd0,   12'd256, 12'd2048, 12'd2048, 12'd0,    CURVE_COS},
		'{12'd200, 12'd150, 12'd1600, 12'd1200, 12'd1000, CURVE_SIN},
		'{12'd256, 12'd256, 12'd4095, 12'd0,    12'd4095, CURVE_SQ},
		'{12'd256, 12'd256, 12'd2040, 12'd2056, 12'd2047, CURVE_INVSQ}
	};

	// Stimulus process.
	initial begin
		longint unsigned x, x2, t, s;
		int unsigned w, h;
		logic [7:0] qc, qr;
		fw_q = 9'd256;
		fh_q = 9'd256;
		cx_q = 12'd2048;
		cy_q = 12'd2048;
		rad_q = 12'd2048;
		curve_q = CURVE_COS;
		// Quarter-wave sine table, odd series to the ninth power in Q2.30.
		for (int i = 0; i < SINE_DEPTH; i++) begin
			x  = (longint'(i) * HALF_PI_Q30) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			t = x;
			s = x;
			t = ((t * x2) >> 30) / 6;  s = s - t;
			t = ((t * x2) >> 30) / 20; s = s + t;
			t = ((t * x2) >> 30) / 42; s = s - t;
			t = ((t * x2) >> 30) / 72; s = s + t;
			s = (s + 8192) >> 14;
			quarter_sine[i] = (s > 65536) ? 17'h10000 : s[16:0];
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].act == ACT_LOAD)
				send_load(directed[i].col, directed[i].row, directed[i].pix);
			else
				send_query(directed[i].col, directed[i].row, directed[i].literal,
					directed[i].want);
		end

		for (int p = 0; p < reg_sets.size() + 2; p++) begin
			drain_pipe();
			if (p < reg_sets.size()) begin
				write_reg(CFG_FRAME_WIDTH,  reg_sets[p].fw);
				write_reg(CFG_FRAME_HEIGHT, reg_sets[p].fh);
				write_reg(CFG_CENTRE_X,     reg_sets[p].cx);
				write_reg(CFG_CENTRE_Y,     reg_sets[p].cy);
				write_reg(CFG_RADIUS,       reg_sets[p].rad);
				write_reg(CFG_CURVE_MODE,   CFG_DW'(reg_sets[p].crv));
			end else begin
				write_reg(CFG_FRAME_WIDTH,  CFG_DW'($urandom_range(1, 256)));
				write_reg(CFG_FRAME_HEIGHT, CFG_DW'($urandom_range(1, 256)));
				write_reg(CFG_CENTRE_X,     CFG_DW'($urandom));
				write_reg(CFG_CENTRE_Y,     CFG_DW'($urandom));
				write_reg(CFG_RADIUS,       CFG_DW'($urandom_range(1, 4095)));
				write_reg(CFG_CURVE_MODE,   CFG_DW'($urandom));
				// Writes past the last register must change nothing.
				write_reg(CFG_SPARE, CFG_DW'($urandom));
			end
			w = (fw_q > MAX_WIDTH) ? MAX_WIDTH : fw_q;
			h = (fh_q > MAX_HEIGHT) ? MAX_HEIGHT : fh_q;
			for (int n = 0; n < QUERIES_PER_SET; n++) begin
				// Occasional overwrites anywhere in the store.
				if ($urandom_range(99) < 15)
					send_load(8'($urandom), 8'($urandom), $urandom);
				// Mostly queries inside the frame, some anywhere.
				if (w != 0 && h != 0 && $urandom_range(99) < 80) begin
					qc = 8'($urandom_range(w - 1));
					qr = 8'($urandom_range(h - 1));
				end else begin
					qc = 8'($urandom);
					qr = 8'($urandom);
				end
				send_query(qc, qr, 1'b0, '0);
			end
		end

		pix_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("radial_warp_remap_tb: clean");
		end else begin
			$display("radial_warp_remap_tb: errors");
		end
		$finish;
	end

	// Result side: random stalls, one long hold-off that backs the pipe up
	// into the request channel, and a stretch with no stalls at all.
	initial begin
		int unsigned cyc;
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= 400 && cyc < 700) res_stall <= 1'b1;
			else if (cyc >= 900 && cyc < 1300) res_stall <= 1'b0;
			else res_stall <= ($urandom_range(99) < 37);
		end
	end

	// Each result taken is matched against the oldest expected one.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_pixels.size() == 0) begin
				error_count++;
				$display("%0t: result with none expected, actual %h/%b", $time,
					res.pixel_out, res.remapped);
			end else begin
				want = pending_pixels.pop_front();
				if (res.pixel_out !== want.pixel_out) begin
					error_count++;
					$display("%0t: pixel_out expected %h actual %h", $time,
						want.pixel_out, res.pixel_out);
				end
				if (res.remapped !== want.remapped) begin
					error_count++;
					$display("%0t: remapped expected %b actual %b", $time,
						want.remapped, res.remapped);
				end
			end
		end
	end

	// Watchdog: too long without any transfer on any channel ends the run.
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("radial_warp_remap_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
